@@ hw/rtl/size_class_pool_allocator_top_assert.svh @@
// Assertion macros used by the allocator checker.
`ifndef SIZE_CLASS_POOL_ALLOCATOR_TOP_ASSERT_SVH
`define SIZE_CLASS_POOL_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define SCPA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication, checked through reset as well.
`define SCPA_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

@@ hw/rtl/scpa_pkg.sv @@
// Shared types, codes and constants of the size class pool allocator.
`timescale 1ns / 1ps
`default_nettype none

package scpa_pkg;

    localparam int NUM_CLASSES = 6;
    localparam int ADDR_W      = 18;
    localparam int SIZE_W      = 16;
    localparam int CLASS_W     = 3;
    localparam int STATUS_W    = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam int CHUNK_BYTES_DEF  = 4096;
    localparam int NUM_CHUNKS_DEF   = 64;
    localparam int STACK_DEPTH_DEF  = 64;
    localparam int HEADER_BYTES_DEF = 8;
    localparam int LINK_BYTES_DEF   = 8;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERSIZE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_STACK_FULL = 2'd3;

    typedef struct packed {
        logic              op;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] block_address;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   result_address;
        logic [CLASS_W-1:0]  size_class;
    } t_rsp;

    typedef struct packed {
        logic               op;
        logic               oversize;
        logic [CLASS_W-1:0] size_class;
        logic [ADDR_W-1:0]  block_address;
    } t_cmd;

    // Block size of a class: 8 bytes doubled per class step.
    function automatic logic [8:0] class_bytes(input logic [CLASS_W-1:0] c);
        return 9'(9'd8 << c);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/scpa_front.sv @@
// Front end: bins each request size into a class and forms a command word.
`timescale 1ns / 1ps
`default_nettype none

module scpa_front (
    input  wire logic          i_push,
    input  wire scpa_pkg::t_req i_req,
    input  wire logic          i_queue_full,
    output logic               o_full,
    output logic               o_cmd_push,
    output scpa_pkg::t_cmd     o_cmd
);

    logic [scpa_pkg::CLASS_W-1:0] cls;
    logic                         over;

    // Walk from the largest class down so the smallest fitting class wins.
    always_comb begin
        cls  = '0;
        over = 1'b1;
        for (int c = scpa_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
            if (i_req.request_size <=
                scpa_pkg::SIZE_W'(scpa_pkg::class_bytes(scpa_pkg::CLASS_W'(c)))) begin
                cls  = scpa_pkg::CLASS_W'(c);
                over = 1'b0;
            end
        end
    end

    always_comb begin
        o_cmd.op            = i_req.op;
        o_cmd.oversize      = over;
        o_cmd.size_class    = cls;
        o_cmd.block_address = i_req.block_address;
    end

    assign o_full     = i_queue_full;
    assign o_cmd_push = i_push && !i_queue_full;

endmodule

`default_nettype wire

@@ hw/rtl/scpa_fifo.sv @@
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module scpa_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire scpa_pkg::t_cmd i_wdata,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output scpa_pkg::t_cmd      o_rdata
);

    localparam int DEPTH = scpa_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    scpa_pkg::t_cmd r_slot [DEPTH];
    logic [PW-1:0]  r_wp, n_wp;
    logic [PW-1:0]  r_rp, n_rp;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/scpa_back.sv @@
// Back end: free stacks, bump pointers, chunk pool and the result register.
`timescale 1ns / 1ps
`default_nettype none

module scpa_back #(
    parameter int CHUNK_BYTES  = scpa_pkg::CHUNK_BYTES_DEF,
    parameter int NUM_CHUNKS   = scpa_pkg::NUM_CHUNKS_DEF,
    parameter int STACK_DEPTH  = scpa_pkg::STACK_DEPTH_DEF,
    parameter int HEADER_BYTES = scpa_pkg::HEADER_BYTES_DEF,
    parameter int LINK_BYTES   = scpa_pkg::LINK_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_valid,
    input  wire scpa_pkg::t_cmd i_cmd,
    output logic                o_cmd_take,
    output logic                o_empty,
    input  wire logic           i_pop,
    output scpa_pkg::t_rsp      o_rsp
);

    localparam int NC  = scpa_pkg::NUM_CLASSES;
    localparam int AW  = scpa_pkg::ADDR_W;
    localparam int MD  = NC * STACK_DEPTH;
    localparam int MAW = $clog2(MD);
    localparam int CNW = $clog2(STACK_DEPTH + 1);
    localparam int LW  = $clog2(CHUNK_BYTES + 1);
    localparam int NCW = $clog2(NUM_CHUNKS + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic [AW-1:0]  r_mem [MD];
    logic [AW-1:0]  r_rd_data;

    logic [CNW-1:0] r_count [NC];
    logic [AW-1:0]  r_bump  [NC];
    logic [LW-1:0]  r_left  [NC];
    logic [NCW-1:0] r_next_chunk, n_next_chunk;
    logic [AW-1:0]  r_next_base, n_next_base;

    logic           r_state, n_state;
    logic [scpa_pkg::CLASS_W-1:0] r_rd_cls, n_rd_cls;
    logic           r_out_valid;
    scpa_pkg::t_rsp r_out, n_out;

    logic                         out_free, take, out_load, cls_we, mem_we, mem_rd;
    logic [scpa_pkg::CLASS_W-1:0] cls;
    logic [CNW-1:0]               cnt, n_cnt;
    logic [AW-1:0]                bump, n_bump, src_base;
    logic [LW-1:0]                left, n_left, src_left, need;
    logic [MAW-1:0]               class_base, mem_addr;
    logic                         room;

    assign out_free   = !r_out_valid || i_pop;
    assign take       = (r_state == S_IDLE) && i_cmd_valid && out_free;
    assign o_cmd_take = take;
    assign o_empty    = !r_out_valid;
    assign o_rsp      = r_out;

    assign cls        = i_cmd.size_class;
    assign cnt        = r_count[cls];
    assign bump       = r_bump[cls];
    assign left       = r_left[cls];
    assign class_base = MAW'(cls) * MAW'(STACK_DEPTH);
    assign need       = LW'(scpa_pkg::class_bytes(cls)) + LW'(HEADER_BYTES);
    assign room       = left >= need + LW'(LINK_BYTES);

    always_comb begin
        n_state      = r_state;
        n_rd_cls     = r_rd_cls;
        n_out        = r_out;
        out_load     = 1'b0;
        cls_we       = 1'b0;
        mem_we       = 1'b0;
        mem_rd       = 1'b0;
        mem_addr     = class_base + MAW'(cnt);
        n_cnt        = cnt;
        n_bump       = bump;
        n_left       = left;
        n_next_chunk = r_next_chunk;
        n_next_base  = r_next_base;
        src_base     = bump;
        src_left     = left;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    priority if (i_cmd.oversize) begin
                        out_load = 1'b1;
                        n_out    = '{scpa_pkg::ST_OVERSIZE, '0, '0};
                    end else if (i_cmd.op == scpa_pkg::OP_FREE) begin
                        out_load = 1'b1;
                        if (cnt == CNW'(STACK_DEPTH)) begin
                            n_out = '{scpa_pkg::ST_STACK_FULL, '0, cls};
                        end else begin
                            mem_we = 1'b1;
                            cls_we = 1'b1;
                            n_cnt  = cnt + 1'b1;
                            n_out  = '{scpa_pkg::ST_OK, '0, cls};
                        end
                    end else if (cnt != '0) begin
                        // Pop the top entry; the result leaves after the read.
                        mem_rd   = 1'b1;
                        mem_addr = class_base + MAW'(cnt) - 1'b1;
                        cls_we   = 1'b1;
                        n_cnt    = cnt - 1'b1;
                        n_rd_cls = cls;
                        n_state  = S_READ;
                    end else if (!room && (r_next_chunk >= NCW'(NUM_CHUNKS))) begin
                        out_load = 1'b1;
                        n_out    = '{scpa_pkg::ST_EXHAUSTED, '0, cls};
                    end else begin
                        if (!room) begin
                            src_base     = r_next_base;
                            src_left     = LW'(CHUNK_BYTES);
                            n_next_chunk = r_next_chunk + 1'b1;
                            n_next_base  = r_next_base + AW'(CHUNK_BYTES);
                        end
                        cls_we   = 1'b1;
                        n_bump   = src_base + AW'(need);
                        n_left   = src_left - need;
                        out_load = 1'b1;
                        n_out    = '{scpa_pkg::ST_OK, src_base + AW'(HEADER_BYTES), cls};
                    end
                end
            end
            S_READ: begin
                out_load = 1'b1;
                n_out    = '{scpa_pkg::ST_OK, r_rd_data, r_rd_cls};
                n_state  = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_next_chunk <= NCW'(NC);
            r_next_base  <= AW'(NC * CHUNK_BYTES);
            for (int c = 0; c < NC; c++) begin
                r_count[c] <= '0;
                r_bump[c]  <= AW'(c * CHUNK_BYTES);
                r_left[c]  <= LW'(CHUNK_BYTES);
            end
        end else begin
            r_state      <= n_state;
            r_next_chunk <= n_next_chunk;
            r_next_base  <= n_next_base;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (cls_we) begin
                r_count[cls] <= n_cnt;
                r_bump[cls]  <= n_bump;
                r_left[cls]  <= n_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_cls <= n_rd_cls;
        if (out_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= i_cmd.block_address;
        end
        if (mem_rd) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/size_class_pool_allocator_top.sv @@
// A result passes the queue slot and the result register. One word per cycle
// while the result register is free or popped, except a pop from a free stack, which
// also uses the read state: the stack memory is single port with registered reads.
// Reset (synchronous, active low) empties the queue and result register, zeroes
// stack counts and restores bump pointers and the chunk pool; stack memory is not
// cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module size_class_pool_allocator_top #(
    parameter int CHUNK_BYTES  = scpa_pkg::CHUNK_BYTES_DEF,
    parameter int NUM_CHUNKS   = scpa_pkg::NUM_CHUNKS_DEF,
    parameter int STACK_DEPTH  = scpa_pkg::STACK_DEPTH_DEF,
    parameter int HEADER_BYTES = scpa_pkg::HEADER_BYTES_DEF,
    parameter int LINK_BYTES   = scpa_pkg::LINK_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    output logic                o_full,
    input  wire scpa_pkg::t_req i_req,
    output logic                o_empty,
    input  wire logic           i_pop,
    output scpa_pkg::t_rsp      o_rsp
);

    logic           queue_full, queue_empty, cmd_push, cmd_take;
    scpa_pkg::t_cmd cmd_in, cmd_out;

    scpa_front u_front (
        .i_push       (i_push),
        .i_req        (i_req),
        .i_queue_full (queue_full),
        .o_full       (o_full),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in)
    );

    scpa_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_wdata (cmd_in),
        .o_full  (queue_full),
        .i_pop   (cmd_take),
        .o_empty (queue_empty),
        .o_rdata (cmd_out)
    );

    scpa_back #(
        .CHUNK_BYTES  (CHUNK_BYTES),
        .NUM_CHUNKS   (NUM_CHUNKS),
        .STACK_DEPTH  (STACK_DEPTH),
        .HEADER_BYTES (HEADER_BYTES),
        .LINK_BYTES   (LINK_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!queue_empty),
        .i_cmd       (cmd_out),
        .o_cmd_take  (cmd_take),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

@@ hw/rtl/scpa_checker.sv @@
// Port-level checks of the allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "size_class_pool_allocator_top_assert.svh"

module scpa_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_full,
    input wire logic           o_empty,
    input wire logic           i_pop,
    input wire scpa_pkg::t_rsp o_rsp
);

    logic rsp_shown;
    assign rsp_shown = !o_empty;

    // Only a successful allocate carries an address.
    `SCPA_ASSERT_IMPL(a_fail_no_addr, i_clk, i_rst_n, rsp_shown && (o_rsp.status != scpa_pkg::ST_OK) && (o_rsp.status != scpa_pkg::ST_STACK_FULL), o_rsp.result_address == '0)
    `SCPA_ASSERT_IMPL(a_oversize_class0, i_clk, i_rst_n, rsp_shown && (o_rsp.status == scpa_pkg::ST_OVERSIZE), o_rsp.size_class == '0)
    `SCPA_ASSERT_IMPL(a_class_range, i_clk, i_rst_n, rsp_shown, o_rsp.size_class < 3'(scpa_pkg::NUM_CLASSES))
    `SCPA_ASSERT_NEXT(a_reset_clean, i_clk, !i_rst_n, o_empty && !o_full)
    `SCPA_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n && rsp_shown && !i_pop, !i_rst_n || (!o_empty && $stable(o_rsp)))

endmodule

bind size_class_pool_allocator_top scpa_checker u_scpa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_full  (o_full),
    .o_empty (o_empty),
    .i_pop   (i_pop),
    .o_rsp   (o_rsp)
);

`default_nettype wire

@@ sim/tb_size_class_pool_allocator_top.sv @@
// Self-checking testbench for the size class pool allocator top level.
`timescale 1ns / 1ps

module tb_size_class_pool_allocator_top;

    import scpa_pkg::*;

    localparam int CHUNK_BYTES  = CHUNK_BYTES_DEF;
    localparam int NUM_CHUNKS   = NUM_CHUNKS_DEF;
    localparam int STACK_DEPTH  = STACK_DEPTH_DEF;
    localparam int HEADER_BYTES = HEADER_BYTES_DEF;
    localparam int LINK_BYTES   = LINK_BYTES_DEF;
    localparam int MAX_BLOCK    = 256;
    localparam int BATCH_LEN    = 12;

    typedef struct {
        logic [CLASS_W-1:0] cls;
        logic [ADDR_W-1:0]  addr;
    } t_live;

    logic i_clk;
    logic i_rst_n;
    logic i_push;
    logic o_full;
    t_req i_req;
    logic o_empty;
    logic i_pop;
    t_rsp o_rsp;

    size_class_pool_allocator_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .o_full  (o_full),
        .i_req   (i_req),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_rsp   (o_rsp)
    );

    // Shadow allocator state
    logic [ADDR_W-1:0] free_stack [NUM_CLASSES][STACK_DEPTH];
    int unsigned       stack_fill [NUM_CLASSES];
    logic [ADDR_W-1:0] bump_ptr   [NUM_CLASSES];
    int unsigned       room_left  [NUM_CLASSES];
    int unsigned       next_chunk;

    t_req  req_backlog [$];
    t_rsp  due_results [$];
    t_live live_blocks [$];

    logic in_taken;
    int   mismatches;
    int   sender_gap_pct;
    int   sink_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_rsp serve_request(t_req r);
        t_rsp        rsp;
        int          cls;
        int unsigned need;
        rsp = '0;
        if (r.request_size > MAX_BLOCK) begin
            rsp.status = ST_OVERSIZE;
            return rsp;
        end
        cls = 0;
        while (r.request_size > (16'd8 << cls)) cls++;
        rsp.size_class = CLASS_W'(cls);
        if (r.op == OP_FREE) begin
            if (stack_fill[cls] >= STACK_DEPTH) begin
                rsp.status = ST_STACK_FULL;
            end else begin
                free_stack[cls][stack_fill[cls]] = r.block_address;
                stack_fill[cls]++;
            end
        end else if (stack_fill[cls] > 0) begin
            stack_fill[cls]--;
            rsp.result_address = free_stack[cls][stack_fill[cls]];
        end else begin
            need = (8 << cls) + HEADER_BYTES;
            // keep the link word at the chunk end; move to a fresh chunk if it won't fit
            if (room_left[cls] < need + LINK_BYTES) begin
                if (next_chunk >= NUM_CHUNKS) begin
                    rsp.status = ST_EXHAUSTED;
                    return rsp;
                end
                bump_ptr[cls]  = ADDR_W'(next_chunk * CHUNK_BYTES);
                room_left[cls] = CHUNK_BYTES;
                next_chunk++;
            end
            rsp.result_address = bump_ptr[cls] + ADDR_W'(HEADER_BYTES);
            bump_ptr[cls]      = bump_ptr[cls] + ADDR_W'(need);
            room_left[cls]     = room_left[cls] - need;
        end
        return rsp;
    endfunction

    task automatic flag_mismatch(string why, t_rsp want, t_rsp got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: status exp %0d got %0d, addr exp %h got %h, class exp %0d got %0d",
                     $realtime, why, want.status, got.status, want.result_address,
                     got.result_address, want.size_class, got.size_class);
    endtask

    // Check popped words and predict accepted ones
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_push && !o_full;
            if (i_pop && !o_empty) begin
                if (due_results.size() == 0) begin
                    flag_mismatch("result with nothing outstanding", '0, o_rsp);
                end else begin
                    want = due_results.pop_front();
                    if (o_rsp.status !== want.status
                        || o_rsp.result_address !== want.result_address
                        || o_rsp.size_class !== want.size_class)
                        flag_mismatch("result mismatch", want, o_rsp);
                end
            end
            if (i_push && !o_full) begin
                want = serve_request(i_req);
                due_results.push_back(want);
                if (i_req.op == OP_ALLOC && want.status == ST_OK)
                    live_blocks.push_back('{want.size_class, want.result_address});
            end
        end
    end

    // Feed words from the backlog; hold a word until it is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_push <= 1'b0;
            i_pop  <= 1'b0;
        end else begin
            i_pop <= ($urandom_range(99) >= sink_stall_pct);
            if (!i_push || in_taken) begin
                if (req_backlog.size() > 0 && $urandom_range(99) >= sender_gap_pct) begin
                    i_req  <= req_backlog.pop_front();
                    i_push <= 1'b1;
                end else begin
                    i_push <= 1'b0;
                end
            end
        end
    end

    task automatic queue_req(logic op, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
        t_req r;
        r.op            = op;
        r.request_size  = size;
        r.block_address = addr;
        req_backlog.push_back(r);
    endtask

    function automatic logic [SIZE_W-1:0] size_for_class(int cls);
        int lo;
        lo = (cls == 0) ? 0 : (4 << cls) + 1;
        return SIZE_W'($urandom_range(8 << cls, lo));
    endfunction

    task automatic take_live(output t_live b);
        int idx;
        idx = $urandom_range(live_blocks.size() - 1);
        b   = live_blocks[idx];
        live_blocks.delete(idx);
    endtask

    task automatic settle_backlog();
        while (req_backlog.size() > 0) @(negedge i_clk);
    endtask

    task automatic drain_all();
        while (req_backlog.size() > 0 || i_push || due_results.size() > 0)
            @(negedge i_clk);
    endtask

    task automatic random_batch();
        int                kind;
        int                pick;
        logic              op;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        t_live             b;
        kind = $urandom_range(99);
        pick = $urandom_range(NUM_CLASSES - 1);
        repeat (BATCH_LEN) begin
            if (kind < 50) begin
                op   = ($urandom_range(99) < 55) ? OP_ALLOC : OP_FREE;
                addr = ADDR_W'($urandom);
                case ($urandom_range(19))
                    0: size = SIZE_W'($urandom_range(65535, MAX_BLOCK + 1));
                    1: size = SIZE_W'($urandom);
                    default: size = SIZE_W'($urandom_range(MAX_BLOCK));
                endcase
                if (op == OP_FREE && live_blocks.size() > 0 && $urandom_range(3) != 0) begin
                    take_live(b);
                    addr = b.addr;
                    size = size_for_class(b.cls);
                end
                queue_req(op, size, addr);
            end else if (kind < 70) begin
                queue_req(OP_ALLOC, size_for_class(pick), ADDR_W'($urandom));
            end else if (kind < 90) begin
                if (live_blocks.size() > 0) begin
                    take_live(b);
                    queue_req(OP_FREE, size_for_class(b.cls), b.addr);
                end else begin
                    queue_req(OP_FREE, size_for_class(pick), ADDR_W'($urandom));
                end
            end else begin
                // noise: any field value at all, mostly oversize
                queue_req(1'($urandom), SIZE_W'($urandom), ADDR_W'($urandom));
            end
        end
        settle_backlog();
    endtask

    initial begin
        int made;
        int seg;
        i_rst_n        = 1'b0;
        i_push         = 1'b0;
        i_pop          = 1'b0;
        i_req          = '0;
        in_taken       = 1'b0;
        mismatches     = 0;
        sender_gap_pct = 0;
        sink_stall_pct = 0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            stack_fill[c] = 0;
            bump_ptr[c]   = ADDR_W'(c * CHUNK_BYTES);
            room_left[c]  = CHUNK_BYTES;
        end
        next_chunk = NUM_CLASSES;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: class boundaries, oversize, pops, double free, extreme fields
        queue_req(OP_ALLOC, 16'd0, '0);
        queue_req(OP_ALLOC, 16'd8, '0);
        queue_req(OP_ALLOC, 16'd9, '1);
        queue_req(OP_ALLOC, 16'd16, '0);
        queue_req(OP_ALLOC, 16'd17, '0);
        queue_req(OP_ALLOC, 16'd32, '0);
        queue_req(OP_ALLOC, 16'd33, '0);
        queue_req(OP_ALLOC, 16'd64, '0);
        queue_req(OP_ALLOC, 16'd65, '0);
        queue_req(OP_ALLOC, 16'd128, '0);
        queue_req(OP_ALLOC, 16'd129, '0);
        queue_req(OP_ALLOC, 16'd256, '0);
        queue_req(OP_ALLOC, 16'd257, '0);
        queue_req(OP_FREE, 16'd257, 18'h0_1000);
        queue_req(OP_ALLOC, 16'hFFFF, '1);
        queue_req(OP_FREE, 16'hFFFF, '1);
        queue_req(OP_FREE, 16'd8, '1);
        queue_req(OP_FREE, 16'd0, '0);
        queue_req(OP_ALLOC, 16'd1, '0);
        queue_req(OP_ALLOC, 16'd5, '0);
        queue_req(OP_FREE, 16'd100, 18'h2_5A5A);
        queue_req(OP_FREE, 16'd100, 18'h2_5A5A);
        queue_req(OP_ALLOC, 16'd70, '0);
        queue_req(OP_ALLOC, 16'd127, '0);
        drain_all();

        // random traffic under four idling patterns
        for (seg = 0; seg < 4; seg++) begin
            case (seg)
                0: begin sender_gap_pct = 0;  sink_stall_pct = 0;  end
                1: begin sender_gap_pct = 50; sink_stall_pct = 0;  end
                2: begin sender_gap_pct = 0;  sink_stall_pct = 50; end
                default: begin sender_gap_pct = 36; sink_stall_pct = 36; end
            endcase
            made = 0;
            while (made < 120) begin
                random_batch();
                made += BATCH_LEN;
            end
        end
        drain_all();

        // overflow one free stack, then pop it empty and bump past it
        sender_gap_pct = 0;
        sink_stall_pct = 0;
        repeat (STACK_DEPTH + 6) queue_req(OP_FREE, size_for_class(3), ADDR_W'($urandom));
        repeat (STACK_DEPTH + 6) queue_req(OP_ALLOC, size_for_class(3), '0);
        drain_all();

        // allocate in every class, then free and take back a large block
        for (int c = 0; c < NUM_CLASSES; c++) begin
            repeat (3) queue_req(OP_ALLOC, size_for_class(c), '0);
        end
        queue_req(OP_FREE, size_for_class(NUM_CLASSES - 1), '1);
        queue_req(OP_ALLOC, size_for_class(NUM_CLASSES - 1), '0);
        queue_req(OP_ALLOC, size_for_class(NUM_CLASSES - 1), '0);
        drain_all();

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("size_class_pool_allocator_top regression: pass");
        end else begin
            $display("size_class_pool_allocator_top regression: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("size_class_pool_allocator_top regression: fail");
        $finish;
    end

endmodule

@@ size_class_pool_allocator_top.f @@
+incdir+hw/rtl
hw/rtl/scpa_pkg.sv
hw/rtl/scpa_front.sv
hw/rtl/scpa_fifo.sv
hw/rtl/scpa_back.sv
hw/rtl/size_class_pool_allocator_top.sv
hw/rtl/scpa_checker.sv
sim/tb_size_class_pool_allocator_top.sv
